/* src/b64se_pkg.sv */
// Shared types, constants and the character table of the base64 stream encoder.
`timescale 1ns / 1ps
package b64se_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [6:0] CharPlus = 7'h2B;
   localparam logic [6:0] CharSlash = 7'h2F;
   localparam logic [6:0] CharPad = 7'h3D;
   localparam logic [6:0] CharPercent = 7'h25;
   localparam logic [6:0] CharTwo = 7'h32;
   localparam logic [6:0] CharThree = 7'h33;
   localparam logic [6:0] CharUpperB = 7'h42;
   localparam logic [6:0] CharUpperF = 7'h46;
   localparam logic [6:0] CharUpperD = 7'h44;

   localparam logic [1:0] SubPercent = 2'd0;
   localparam logic [1:0] SubDigit = 2'd1;
   localparam logic [1:0] SubLetter = 2'd2;

   localparam logic [1:0] CharLast = 2'd3;
   localparam logic [1:0] GroupFull = 2'd3;

   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  nbytes;
      logic        last;
   } group_entry_type;

   typedef struct packed {
      logic            valid;
      group_entry_type entry;
   } queue_head_type;

   function automatic logic [6:0] b64_char(input logic [5:0] idx);
      logic [6:0] ch;
      if (idx < 6'd26) begin
         ch = 7'h41 + {1'b0, idx};
      end else if (idx < 6'd52) begin
         ch = 7'h61 + {1'b0, idx} - 7'd26;
      end else if (idx < 6'd62) begin
         ch = 7'h30 + {1'b0, idx} - 7'd52;
      end else if (idx == 6'd62) begin
         ch = CharPlus;
      end else begin
         ch = CharSlash;
      end
      return ch;
   endfunction

endpackage

/* src/base64_stream_encoder.sv */
// Top level of the base64 stream encoder: configuration register and part wiring.
// A closing byte's group is written to the queue, then its first character is registered.
// The sequencer gives one character per cycle while rsp_stall is low; a group gives four
// characters, or up to twelve with url escaping.
// Bytes are accepted every cycle while the four-entry group queue has room.
// Synchronous reset clears pending bytes, the queue, the sequencer and url escaping.
`timescale 1ns / 1ps
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_end_of_run,
   output logic       rsp_end_of_message,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic                       url_escape_ff, url_escape_in;
   logic                       push, pop, queue_full;
   b64se_pkg::group_entry_type push_entry;
   b64se_pkg::queue_head_type  head;

   assign url_escape_in = csr_wr_en ? csr_wr_data : url_escape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         url_escape_ff <= 1'b0;
      end else begin
         url_escape_ff <= url_escape_in;
      end
   end

   b64se_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   b64se_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head       (head)
   );

   b64se_back u_back (
      .clock              (clock),
      .reset              (reset),
      .url_escape         (url_escape_ff),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_end_of_run     (rsp_end_of_run),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

/* src/b64se_front.sv */
// Front end: accepts bytes, holds pending bytes and forms three-byte groups.
`timescale 1ns / 1ps
module b64se_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   input  logic                      queue_full,
   output logic                      push,
   output b64se_pkg::group_entry_type push_entry
);

   logic [15:0] pending_bytes_ff, pending_bytes_in;
   logic [1:0]  pending_count_ff, pending_count_in;
   logic [1:0]  count_clamped;
   logic [1:0]  nbytes;
   logic        accept;

   assign req_stall = queue_full;
   assign accept = req_valid & ~queue_full;

   always_comb begin
      count_clamped = (pending_count_ff == 2'd3) ? 2'd2 : pending_count_ff;
      nbytes = count_clamped + 2'd1;
      case (count_clamped)
         2'd0: push_entry.group = {req_data_byte, 16'h0000};
         2'd1: push_entry.group = {pending_bytes_ff[7:0], req_data_byte, 8'h00};
         default: push_entry.group = {pending_bytes_ff, req_data_byte};
      endcase
      push_entry.nbytes = nbytes;
      push_entry.last = req_last_byte;
      push = accept & ((nbytes == b64se_pkg::GroupFull) | req_last_byte);
      pending_bytes_in = pending_bytes_ff;
      pending_count_in = pending_count_ff;
      if (push) begin
         pending_bytes_in = 16'h0000;
         pending_count_in = 2'd0;
      end else if (accept) begin
         pending_bytes_in = {pending_bytes_ff[7:0], req_data_byte};
         pending_count_in = nbytes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bytes_ff <= 16'h0000;
         pending_count_ff <= 2'd0;
      end else begin
         pending_bytes_ff <= pending_bytes_in;
         pending_count_ff <= pending_count_in;
      end
   end

   a_pending_below_three: assert property (@(posedge clock) disable iff (reset)
      pending_count_ff != 2'd3)
      else $error("pending count reached three");

endmodule

/* src/b64se_queue.sv */
// Short queue of formed groups between the front end and the character sequencer.
`timescale 1ns / 1ps
module b64se_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64se_pkg::group_entry_type push_entry,
   input  logic                       pop,
   output logic                       full,
   output b64se_pkg::queue_head_type  head
);

   b64se_pkg::group_entry_type slots_ff [b64se_pkg::QueueDepth];
   logic [b64se_pkg::QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [b64se_pkg::QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [b64se_pkg::QueueCountWidth-1:0] count_ff, count_in;
   logic                                  do_push, do_pop;

   always_comb begin
      full = (count_ff == b64se_pkg::QueueCountWidth'(b64se_pkg::QueueDepth));
      head.valid = (count_ff != '0);
      head.entry = slots_ff[rd_ptr_ff];
      do_push = push & ~full;
      do_pop = pop & head.valid;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= b64se_pkg::QueueCountWidth'(b64se_pkg::QueueDepth))
      else $error("queue count beyond depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("item pushed into full queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[b64se_pkg::QueuePtrWidth-1:0])
      else $error("queue pointers disagree with count");

endmodule

/* src/b64se_back.sv */
// Back end: steps through the four characters of a group, escaping and registering each.
`timescale 1ns / 1ps
module b64se_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      url_escape,
   input  b64se_pkg::queue_head_type head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [6:0]                rsp_out_char,
   output logic                      rsp_end_of_run,
   output logic                      rsp_end_of_message
);

   logic [1:0] char_ff, char_in;
   logic [1:0] sub_ff, sub_in;
   logic       valid_ff, valid_in;
   logic [6:0] out_char_ff, out_char_in;
   logic       eor_ff, eor_in;
   logic       eom_ff, eom_in;
   logic [5:0] sextet;
   logic [6:0] base_char;
   logic       special;
   logic       sub_done;
   logic       advance;

   always_comb begin
      case (char_ff)
         2'd0: sextet = head.entry.group[23:18];
         2'd1: sextet = head.entry.group[17:12];
         2'd2: sextet = head.entry.group[11:6];
         default: sextet = head.entry.group[5:0];
      endcase
      base_char = (char_ff > head.entry.nbytes) ? b64se_pkg::CharPad
                                                : b64se_pkg::b64_char(sextet);
      special = url_escape & ((base_char == b64se_pkg::CharPlus)
                              | (base_char == b64se_pkg::CharSlash)
                              | (base_char == b64se_pkg::CharPad));
      sub_done = ~special | (sub_ff == b64se_pkg::SubLetter);
      advance = head.valid & (~valid_ff | ~rsp_stall);

      case (sub_ff)
         b64se_pkg::SubPercent: out_char_in = special ? b64se_pkg::CharPercent : base_char;
         b64se_pkg::SubDigit: out_char_in = (base_char == b64se_pkg::CharPad)
                                            ? b64se_pkg::CharThree : b64se_pkg::CharTwo;
         b64se_pkg::SubLetter: begin
            if (base_char == b64se_pkg::CharPlus) begin
               out_char_in = b64se_pkg::CharUpperB;
            end else if (base_char == b64se_pkg::CharSlash) begin
               out_char_in = b64se_pkg::CharUpperF;
            end else begin
               out_char_in = b64se_pkg::CharUpperD;
            end
         end
         default: out_char_in = base_char;
      endcase

      eor_in = sub_done & (char_ff == b64se_pkg::CharLast);
      eom_in = eor_in & head.entry.last;
      pop = advance & eor_in;

      char_in = char_ff;
      sub_in = sub_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
         if (sub_done) begin
            sub_in = b64se_pkg::SubPercent;
            char_in = char_ff + 2'd1;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= 2'd0;
         sub_ff <= b64se_pkg::SubPercent;
         valid_ff <= 1'b0;
      end else begin
         char_ff <= char_in;
         sub_ff <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_char_ff <= out_char_in;
         eor_ff <= eor_in;
         eom_ff <= eom_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_end_of_run = eor_ff;
   assign rsp_end_of_message = eom_ff;

   a_sub_in_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 2'd3)
      else $error("escape step out of range");

   a_eom_on_eor: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && eom_ff) |-> eor_ff)
      else $error("end of message without end of run");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      pop |=> (char_ff == 2'd0 && sub_ff == b64se_pkg::SubPercent))
      else $error("sequencer not rewound after group");

endmodule
